### hw/rtl/frame_difference_motion_detector_core_defines.svh
// ----------------------------------------------------------------------------
// Frame difference motion detector assertion macros
// Shared concurrent assertion templates for the detector RTL.
// ----------------------------------------------------------------------------
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_CORE_DEFINES_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDMD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdmd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FDMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdmd assertion failed");

`endif

### hw/rtl/fdmd_pkg.sv
// ----------------------------------------------------------------------------
// Frame difference motion detector package
// Field widths, register defaults, register indexes and interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdmd_pkg;

   localparam int DEFAULT_MAX_PIXELS = 524288;

   localparam int PIXEL_W     = 8;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 10;
   localparam int THR_W       = 8;
   localparam int FRAME_SUM_W = 27;
   localparam int PROD_W      = WIDTH_W + HEIGHT_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
   localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(8);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_MEAN_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctrl_type;

   typedef struct packed {
      logic a_valid;   // item waiting on store data / write-back
      logic a_free;    // stage A can take an item this cycle
      logic b_valid;   // finished frame result waiting for the output register
   } accum_status_type;

endpackage

### hw/rtl/fdmd_frame_store.sv
// ----------------------------------------------------------------------------
// Frame store
// Previous-frame pixel memory, one read and one write port, registered read,
// write-to-read forwarding and a fill count standing in for a reset clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdmd_frame_store #(
   parameter int MAX_PIXELS = fdmd_pkg::DEFAULT_MAX_PIXELS,
   parameter int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
   parameter int CNT_W      = $clog2(MAX_PIXELS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fdmd_pkg::store_ctrl_type         ctrl,
   input  logic [ADDR_W-1:0]                rd_addr,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic [fdmd_pkg::PIXEL_W-1:0]     wr_data,
   output logic [fdmd_pkg::PIXEL_W-1:0]     rd_data
);

   logic [fdmd_pkg::PIXEL_W-1:0] mem [MAX_PIXELS];

   logic [fdmd_pkg::PIXEL_W-1:0] rd_data_ff;
   logic [fdmd_pkg::PIXEL_W-1:0] fwd_data_ff;
   logic                         fwd_ff;
   logic                         fwd_in;
   logic                         hit_ff;
   logic                         hit_in;
   logic [CNT_W-1:0]             fill_ff;
   logic [CNT_W-1:0]             fill_in;
   logic [CNT_W-1:0]             wr_end;

   // Positions are visited in order from zero, so written entries form a prefix.
   assign wr_end  = CNT_W'(wr_addr) + CNT_W'(1);
   assign fill_in = (ctrl.wr_en && (wr_end > fill_ff)) ? wr_end : fill_ff;
   assign hit_in  = CNT_W'(rd_addr) < fill_ff;
   assign fwd_in  = ctrl.wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         hit_ff      <= hit_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Unwritten entries read as black.
   assign rd_data = fwd_ff ? fwd_data_ff : (hit_ff ? rd_data_ff : '0);

endmodule

### hw/rtl/fdmd_sad_accum.sv
// ----------------------------------------------------------------------------
// Absolute difference accumulator
// Takes store read data, forms the absolute difference, writes the pixel back,
// keeps the frame sum and holds the finished frame sum and limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdmd_sad_accum #(
   parameter int ADDR_W = 19,
   parameter int CNT_W  = 20,
   parameter int SUM_W  = CNT_W + fdmd_pkg::PIXEL_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_load,
   input  logic [fdmd_pkg::PIXEL_W-1:0]     in_pixel,
   input  logic [ADDR_W-1:0]                in_addr,
   input  logic                             in_last,
   input  logic [CNT_W-1:0]                 in_count,
   input  logic [fdmd_pkg::THR_W-1:0]       in_threshold,
   input  logic [fdmd_pkg::PIXEL_W-1:0]     old_pixel,
   input  logic                             out_take,
   output fdmd_pkg::accum_status_type       status,
   output logic                             wr_en,
   output logic [ADDR_W-1:0]                wr_addr,
   output logic [fdmd_pkg::PIXEL_W-1:0]     wr_data,
   output logic [SUM_W-1:0]                 b_sum,
   output logic [SUM_W-1:0]                 b_limit
);

   logic                         a_valid_ff;
   logic                         a_valid_in;
   logic [fdmd_pkg::PIXEL_W-1:0] a_pixel_ff;
   logic [ADDR_W-1:0]            a_addr_ff;
   logic                         a_last_ff;
   logic [CNT_W-1:0]             a_count_ff;
   logic [fdmd_pkg::THR_W-1:0]   a_thr_ff;

   logic                         b_valid_ff;
   logic                         b_valid_in;
   logic [SUM_W-1:0]             b_sum_ff;
   logic [SUM_W-1:0]             b_limit_ff;

   logic [SUM_W-1:0]             sum_ff;
   logic [SUM_W-1:0]             sum_in;
   logic [SUM_W-1:0]             sum_acc;
   logic [fdmd_pkg::PIXEL_W-1:0] diff;

   logic                         a_adv;
   logic                         b_free;

   assign b_free = !b_valid_ff || out_take;
   // Only a frame-ending item needs room in stage B.
   assign a_adv  = a_valid_ff && (!a_last_ff || b_free);

   assign diff    = (a_pixel_ff > old_pixel) ? (a_pixel_ff - old_pixel)
                                             : (old_pixel - a_pixel_ff);
   assign sum_acc = sum_ff + SUM_W'(diff);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (in_load) begin
         a_valid_in = 1'b1;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end

      b_valid_in = b_valid_ff;
      if (a_adv && a_last_ff) begin
         b_valid_in = 1'b1;
      end else if (out_take) begin
         b_valid_in = 1'b0;
      end

      sum_in = sum_ff;
      if (a_adv) begin
         sum_in = a_last_ff ? '0 : sum_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         a_pixel_ff <= in_pixel;
         a_addr_ff  <= in_addr;
         a_last_ff  <= in_last;
         a_count_ff <= in_count;
         a_thr_ff   <= in_threshold;
      end
      if (a_adv && a_last_ff) begin
         b_sum_ff   <= sum_acc;
         b_limit_ff <= SUM_W'(a_thr_ff) * SUM_W'(a_count_ff);
      end
   end

   assign status.a_valid = a_valid_ff;
   assign status.a_free  = !a_valid_ff || a_adv;
   assign status.b_valid = b_valid_ff;

   assign wr_en   = a_adv;
   assign wr_addr = a_addr_ff;
   assign wr_data = a_pixel_ff;
   assign b_sum   = b_sum_ff;
   assign b_limit = b_limit_ff;

endmodule

### hw/rtl/frame_difference_motion_detector_core.sv
// ----------------------------------------------------------------------------
// Frame difference motion detector core
// Sum of absolute differences against the stored previous frame, one motion
// verdict per frame.
// ----------------------------------------------------------------------------
// Takes one gray pixel per clock in raster order unless stalled and presents one
// registered item per frame on the result port. The item holds the frame's sum of
// absolute differences and a flag that is set when the sum exceeds mean_threshold
// times the pixel count (width times height, a zero size counts as one pixel,
// clamped to MAX_PIXELS). The frame store is a single memory that is read when a
// pixel is accepted and written back from stage A, with the just-written pixel
// forwarded when the next read hits the same entry. A stalled result holds the
// output register and a second finished frame waits behind it; pixels keep flowing
// until the last pixel of a third frame is taken, then the input stalls until the
// result is accepted. After reset the store reads as black with no clearing pass;
// a fill count tracks which entries have been written. The user must write
// registers only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps

`include "frame_difference_motion_detector_core_defines.svh"

module frame_difference_motion_detector_core #(
   parameter int MAX_PIXELS = fdmd_pkg::DEFAULT_MAX_PIXELS
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fdmd_pkg::PIXEL_W-1:0]         req_gray_pixel,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fdmd_pkg::FRAME_SUM_W-1:0]     rsp_frame_sum,
   output logic                                 rsp_motion_detected,

   input  logic                                 csr_write_en,
   input  logic [fdmd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fdmd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W  = CNT_W + fdmd_pkg::PIXEL_W;

   logic [fdmd_pkg::WIDTH_W-1:0]      width_ff;
   logic [fdmd_pkg::HEIGHT_W-1:0]     height_ff;
   logic [fdmd_pkg::THR_W-1:0]        thr_ff;

   logic [ADDR_W-1:0]                 pos_ff;
   logic [ADDR_W-1:0]                 pos_in;

   logic [fdmd_pkg::PROD_W-1:0]       area;
   logic [CNT_W-1:0]                  pixel_count;
   logic                              count_ok;
   logic                              frame_last;
   logic                              req_accept;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [fdmd_pkg::FRAME_SUM_W-1:0]  rsp_sum_ff;
   logic                              rsp_motion_ff;
   logic                              o_free;

   fdmd_pkg::accum_status_type        acc_status;
   fdmd_pkg::store_ctrl_type          store_ctrl;
   logic                              wr_en;
   logic [ADDR_W-1:0]                 wr_addr;
   logic [fdmd_pkg::PIXEL_W-1:0]      wr_data;
   logic [fdmd_pkg::PIXEL_W-1:0]      old_pixel;
   logic [SUM_W-1:0]                  b_sum;
   logic [SUM_W-1:0]                  b_limit;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fdmd_pkg::WIDTH_RESET;
         height_ff <= fdmd_pkg::HEIGHT_RESET;
         thr_ff    <= fdmd_pkg::THR_RESET;
      end else if (csr_write_en) begin
         unique case (fdmd_pkg::csr_index_type'(csr_index))
            fdmd_pkg::CSR_FRAME_WIDTH: begin
               width_ff <= csr_wdata[fdmd_pkg::WIDTH_W-1:0];
            end
            fdmd_pkg::CSR_FRAME_HEIGHT: begin
               height_ff <= csr_wdata[fdmd_pkg::HEIGHT_W-1:0];
            end
            fdmd_pkg::CSR_MEAN_THRESHOLD: begin
               thr_ff <= csr_wdata[fdmd_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pixel count from the current registers
   assign area = fdmd_pkg::PROD_W'(width_ff) * fdmd_pkg::PROD_W'(height_ff);

   always_comb begin
      if (area == '0) begin
         pixel_count = CNT_W'(1);
      end else if (32'(area) > 32'(MAX_PIXELS)) begin
         pixel_count = CNT_W'(MAX_PIXELS);
      end else begin
         pixel_count = CNT_W'(area);
      end
   end

   assign req_stall  = !acc_status.a_free;
   assign req_accept = req_valid && !req_stall;
   assign frame_last = (32'(pos_ff) + 32'd1) >= 32'(pixel_count);
   assign pos_in     = frame_last ? '0 : (pos_ff + ADDR_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (req_accept) begin
         pos_ff <= pos_in;
      end
   end

   assign store_ctrl.rd_en = req_accept;
   assign store_ctrl.wr_en = wr_en;

   fdmd_frame_store #(
      .MAX_PIXELS (MAX_PIXELS),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (store_ctrl),
      .rd_addr (pos_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (old_pixel)
   );

   fdmd_sad_accum #(
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W),
      .SUM_W  (SUM_W)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .in_load      (req_accept),
      .in_pixel     (req_gray_pixel),
      .in_addr      (pos_ff),
      .in_last      (frame_last),
      .in_count     (pixel_count),
      .in_threshold (thr_ff),
      .old_pixel    (old_pixel),
      .out_take     (o_free),
      .status       (acc_status),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .b_sum        (b_sum),
      .b_limit      (b_limit)
   );

   // Output register
   assign o_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = o_free ? acc_status.b_valid : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (o_free && acc_status.b_valid) begin
         rsp_sum_ff    <= fdmd_pkg::FRAME_SUM_W'(b_sum);
         rsp_motion_ff <= b_sum > b_limit;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_sum       = rsp_sum_ff;
   assign rsp_motion_detected = rsp_motion_ff;

   assign count_ok = (pixel_count != '0) && (32'(pixel_count) <= 32'(MAX_PIXELS));

   `FDMD_ASSERT_NEXT(accept_fills_stage_a, clock, reset, req_accept, acc_status.a_valid)
   `FDMD_ASSERT_NEXT(pos_wraps_after_last, clock, reset, req_accept && frame_last, pos_ff == '0)
   `FDMD_ASSERT_SAME(count_in_range, clock, reset, 1'b1, count_ok)

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Frame difference motion detector testbench
// Feeds gray pixels through the valid/stall input channel. A local model of
// the frame store, running sum and registers predicts one verdict per frame,
// and each verdict leaving the result channel is checked against it, or against a
// typed row's own verdict. A short table of directed rows runs first. Then come a
// long receiver hold-off and a partial oversized frame closed by a shrink to one
// pixel. Random frames with random sizes, thresholds and pixel patterns follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int PIXEL_W     = fdmd_pkg::PIXEL_W;
   localparam int WIDTH_W     = fdmd_pkg::WIDTH_W;
   localparam int HEIGHT_W    = fdmd_pkg::HEIGHT_W;
   localparam int THR_W       = fdmd_pkg::THR_W;
   localparam int FRAME_SUM_W = fdmd_pkg::FRAME_SUM_W;
   localparam int CSR_IDX_W   = fdmd_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = fdmd_pkg::CSR_DATA_W;

   localparam int STORE_DEPTH    = fdmd_pkg::DEFAULT_MAX_PIXELS;
   localparam int RANDOM_ITEMS   = 470;
   localparam int OVERSIZE_ITEMS = 16;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REGISTER = 2'd3;

   typedef struct packed {
      logic [FRAME_SUM_W-1:0] frame_sum;
      logic                   motion;
   } verdict_type;

   typedef enum logic [0:0] {
      ROW_REG_WRITE,
      ROW_PIXEL
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  data;
      logic [PIXEL_W-1:0]     pixel;
      logic                   typed;
      verdict_type            want;
   } stim_row_type;

   typedef enum logic [2:0] {
      FILL_RANDOM,
      FILL_STILL,
      FILL_EXTREME,
      FILL_DRIFT,
      FILL_OPPOSITE
   } fill_mode_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [PIXEL_W-1:0]      req_gray_pixel;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [FRAME_SUM_W-1:0]  rsp_frame_sum;
   logic                    rsp_motion_detected;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // model of the block
   logic [PIXEL_W-1:0]      stored_frame [STORE_DEPTH];
   int unsigned             model_position;
   logic [27:0]             model_sum;
   logic [WIDTH_W-1:0]      reg_width;
   logic [HEIGHT_W-1:0]     reg_height;
   logic [THR_W-1:0]        reg_threshold;

   verdict_type             pending_verdicts [$];
   stim_row_type            directed_rows [$];
   int                      error_count;
   bit                      quiet_mode;
   bit                      hold_go;

   frame_difference_motion_detector_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_gray_pixel      (req_gray_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_sum       (rsp_frame_sum),
      .rsp_motion_detected (rsp_motion_detected),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // zero size counts as one pixel, large sizes clamp to the store depth
   function automatic int unsigned frame_pixels();
      int unsigned n;
      n = reg_width * reg_height;
      if (n == 0) n = 1;
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      return n;
   endfunction

   task automatic predict_frame_step(input logic [PIXEL_W-1:0] pix, output logic done,
                                     output verdict_type verdict);
      int unsigned        count;
      int unsigned        addr;
      logic [PIXEL_W-1:0] prior;
      logic [PIXEL_W-1:0] diff;
      longint unsigned    limit;
      longint unsigned    total;
      count = frame_pixels();
      addr = model_position;
      if (addr >= STORE_DEPTH) addr = 0;
      prior = stored_frame[addr];
      diff = (pix > prior) ? pix - prior : prior - pix;
      stored_frame[addr] = pix;
      model_sum = model_sum + 28'(diff);
      verdict = '0;
      // count may have shrunk under a partial frame: end at the first pixel past it
      done = (addr + 1 >= count);
      if (done) begin
         limit = reg_threshold;
         limit = limit * count;
         total = model_sum;
         verdict.frame_sum = model_sum[FRAME_SUM_W-1:0];
         verdict.motion = (total > limit);
         model_position = 0;
         model_sum = '0;
      end else begin
         model_position = addr + 1;
      end
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel(input fill_mode_type mode);
      logic [PIXEL_W-1:0] prior;
      int                 drift;
      prior = stored_frame[model_position];
      case (mode)
         FILL_STILL:    return prior;
         FILL_EXTREME:  return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         FILL_DRIFT: begin
            drift = int'(prior) + int'($urandom_range(0, 6)) - 3;
            if (drift < 0) drift = 0;
            if (drift > 255) drift = 255;
            return drift[PIXEL_W-1:0];
         end
         FILL_OPPOSITE: return prior[PIXEL_W-1] ? 8'h00 : 8'hFF;
         default:       return PIXEL_W'($urandom);
      endcase
   endfunction

   // registers only change with nothing in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         fdmd_pkg::CSR_FRAME_WIDTH:    reg_width = data[WIDTH_W-1:0];
         fdmd_pkg::CSR_FRAME_HEIGHT:   reg_height = data[HEIGHT_W-1:0];
         fdmd_pkg::CSR_MEAN_THRESHOLD: reg_threshold = data[THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic typed,
                             input verdict_type typed_want);
      int          gap;
      logic        done;
      verdict_type verdict;
      gap = quiet_mode ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_gray_pixel <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame_step(pix, done, verdict);
      if (typed) pending_verdicts.push_back(typed_want);
      else if (done) pending_verdicts.push_back(verdict);
   endtask

   task automatic add_reg_row(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '0;
      row.kind = ROW_REG_WRITE;
      row.index = idx;
      row.data = data;
      directed_rows.push_back(row);
   endtask

   task automatic add_pixel_row(input logic [PIXEL_W-1:0] pix, input logic typed,
                                input logic [FRAME_SUM_W-1:0] sum, input logic motion);
      stim_row_type row;
      row = '0;
      row.kind = ROW_PIXEL;
      row.pixel = pix;
      row.typed = typed;
      row.want.frame_sum = sum;
      row.want.motion = motion;
      directed_rows.push_back(row);
   endtask

   // result side: random stall, plus one long hold-off on request
   initial begin : result_sink
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            hold = quiet_mode ? 0 : idle_length();
            if (hold == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               repeat (hold - 1) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : verdict_check
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected item: sum=%0d motion=%0b",
                                      rsp_frame_sum, rsp_motion_detected));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_frame_sum !== want.frame_sum)
               report_mismatch($sformatf("frame_sum: got %0d, want %0d",
                                         rsp_frame_sum, want.frame_sum));
            if (rsp_motion_detected !== want.motion)
               report_mismatch($sformatf("motion_detected: got %0b, want %0b (sum %0d)",
                                         rsp_motion_detected, want.motion, want.frame_sum));
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d items outstanding",
               WATCHDOG_LIMIT, pending_verdicts.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int            random_items;
      int unsigned   count;
      int            frames;
      int            partial;
      int            w;
      int            h;
      logic [7:0]    thr;
      fill_mode_type mode;
      stim_row_type  row;

      reset = 1'b1;
      req_valid = 1'b0;
      req_gray_pixel = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count = 0;
      quiet_mode = 1'b0;
      hold_go = 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) stored_frame[i] = '0;
      model_position = 0;
      model_sum = '0;
      reg_width = fdmd_pkg::WIDTH_RESET;
      reg_height = fdmd_pkg::HEIGHT_RESET;
      reg_threshold = fdmd_pkg::THR_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-pixel frames: first one sees a black store
      add_reg_row(fdmd_pkg::CSR_FRAME_WIDTH, 11'd1);
      add_reg_row(fdmd_pkg::CSR_FRAME_HEIGHT, 11'd1);
      add_reg_row(fdmd_pkg::CSR_MEAN_THRESHOLD, 11'd0);
      add_pixel_row(8'd255, 1'b1, 27'd255, 1'b1);
      add_pixel_row(8'd255, 1'b1, 27'd0, 1'b0);
      add_pixel_row(8'd0, 1'b1, 27'd255, 1'b1);
      add_pixel_row(8'd0, 1'b1, 27'd0, 1'b0);
      // high data bits are dropped: threshold 255, sum must exceed, not equal
      add_reg_row(fdmd_pkg::CSR_MEAN_THRESHOLD, 11'h7FF);
      add_pixel_row(8'd255, 1'b1, 27'd255, 1'b0);
      add_pixel_row(8'd0, 1'b1, 27'd255, 1'b0);
      // zero width, then zero height: one pixel per frame
      add_reg_row(fdmd_pkg::CSR_FRAME_WIDTH, 11'd0);
      add_pixel_row(8'd128, 1'b1, 27'd128, 1'b0);
      add_reg_row(fdmd_pkg::CSR_FRAME_HEIGHT, 11'h400);
      add_reg_row(fdmd_pkg::CSR_FRAME_WIDTH, 11'd1);
      add_pixel_row(8'd128, 1'b1, 27'd0, 1'b0);
      add_reg_row(CSR_NO_REGISTER, 11'h7FF);
      add_pixel_row(8'd1, 1'b1, 27'd127, 1'b0);
      // 4x2 frame, threshold write with bit 8 set reads as zero
      add_reg_row(fdmd_pkg::CSR_FRAME_WIDTH, 11'd4);
      add_reg_row(fdmd_pkg::CSR_FRAME_HEIGHT, 11'h402);
      add_reg_row(fdmd_pkg::CSR_MEAN_THRESHOLD, 11'h100);
      add_pixel_row(8'h00, 1'b0, '0, 1'b0);
      add_pixel_row(8'hFF, 1'b0, '0, 1'b0);
      add_pixel_row(8'h01, 1'b0, '0, 1'b0);
      add_pixel_row(8'hFE, 1'b0, '0, 1'b0);
      add_pixel_row(8'h55, 1'b0, '0, 1'b0);
      add_pixel_row(8'hAA, 1'b0, '0, 1'b0);
      add_pixel_row(8'h0F, 1'b0, '0, 1'b0);
      add_pixel_row(8'hF0, 1'b0, '0, 1'b0);
      // half a frame, then shrink the size under it
      add_reg_row(fdmd_pkg::CSR_MEAN_THRESHOLD, 11'd255);
      add_pixel_row(8'hFF, 1'b0, '0, 1'b0);
      add_pixel_row(8'h00, 1'b0, '0, 1'b0);
      add_pixel_row(8'h80, 1'b0, '0, 1'b0);
      add_pixel_row(8'h7F, 1'b0, '0, 1'b0);
      add_reg_row(fdmd_pkg::CSR_FRAME_WIDTH, 11'd1);
      add_reg_row(fdmd_pkg::CSR_FRAME_HEIGHT, 11'd1);
      add_pixel_row(8'h07, 1'b0, '0, 1'b0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_REG_WRITE) write_reg(row.index, row.data);
         else send_pixel(row.pixel, row.typed, row.want);
      end

      // receiver holds off while two-pixel frames pile up
      write_reg(fdmd_pkg::CSR_FRAME_WIDTH, 11'd1);
      write_reg(fdmd_pkg::CSR_FRAME_HEIGHT, 11'd2);
      hold_go = 1'b1;
      quiet_mode = 1'b1;
      for (int i = 0; i < 30; i++) send_pixel(pick_pixel(FILL_RANDOM), 1'b0, '0);
      quiet_mode = 1'b0;

      // oversized frame clamps to the full store; close it early with a 1x1 size
      write_reg(fdmd_pkg::CSR_FRAME_WIDTH, 11'h7FF);
      write_reg(fdmd_pkg::CSR_FRAME_HEIGHT, 11'h3FF);
      write_reg(fdmd_pkg::CSR_MEAN_THRESHOLD, 11'd254);
      quiet_mode = 1'b1;
      for (int i = 0; i < OVERSIZE_ITEMS; i++)
         send_pixel(pick_pixel(FILL_OPPOSITE), 1'b0, '0);
      quiet_mode = 1'b0;
      write_reg(fdmd_pkg::CSR_FRAME_WIDTH, 11'd1);
      write_reg(fdmd_pkg::CSR_FRAME_HEIGHT, 11'd1);
      send_pixel(pick_pixel(FILL_OPPOSITE), 1'b0, '0);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 4);
         if ($urandom_range(0, 9) == 0) w = 0;
         if ($urandom_range(0, 9) == 0) h = 0;
         thr = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
         if ($urandom_range(0, 3) != 0)
            write_reg(fdmd_pkg::CSR_FRAME_WIDTH, 11'(w));
         if ($urandom_range(0, 3) != 0)
            write_reg(fdmd_pkg::CSR_FRAME_HEIGHT, {1'($urandom), 10'(h)});
         if ($urandom_range(0, 3) != 0)
            write_reg(fdmd_pkg::CSR_MEAN_THRESHOLD, {3'($urandom), thr});
         quiet_mode = ($urandom_range(0, 4) == 0);
         mode = fill_mode_type'($urandom_range(0, 4));
         count = frame_pixels();
         frames = $urandom_range(1, 4);
         partial = ($urandom_range(0, 4) == 0) ? $urandom_range(1, count) : 0;
         for (int i = 0; i < frames * count + partial; i++) begin
            send_pixel(pick_pixel(mode), 1'b0, '0);
            random_items++;
         end
      end
      quiet_mode = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/fdmd_pkg.sv
hw/rtl/fdmd_frame_store.sv
hw/rtl/fdmd_sad_accum.sv
hw/rtl/frame_difference_motion_detector_core.sv
bench/testbench.sv
